// ===== sv/msm_pkg.sv =====
// Package for the multichannel sample mixer: sizes, request and state codes,
// and the structs that carry memory write requests between modules.
// No dependencies.
package msm_pkg;

  localparam int MAX_CHANNELS  = 8;
  localparam int MEM_ADDR_BITS = 16;
  localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
  localparam int CH_BITS       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_RAW       = $clog2(MAX_CHANNELS + 1);
  localparam int CNT_W         = (CNT_RAW < 4) ? 4 : CNT_RAW;
  localparam int LEN_W         = 17;
  localparam int BASE_W        = 16;

  typedef enum logic [1:0] {
    REQ_WRITE     = 2'd0,
    REQ_PLAY_FREE = 2'd1,
    REQ_PLAY_CH   = 2'd2,
    REQ_TICK      = 2'd3
  } req_t;

  typedef enum logic [0:0] {
    CFG_NUM_CHANNELS  = 1'b0,
    CFG_NUM_PROTECTED = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pos;
  } chan_entry_t;

  typedef struct packed {
    logic               we;
    logic [CH_BITS-1:0] addr;
    chan_entry_t        data;
  } chan_wr_t;

  typedef struct packed {
    logic                     we;
    logic [MEM_ADDR_BITS-1:0] addr;
    logic [15:0]              data;
  } sample_wr_t;

endpackage

// ===== sv/msm_sample_mem.sv =====
// Sample memory of the mixer: one stereo frame per address, left byte low.
// One write port, one read port with registered data. Depends on msm_pkg.
module msm_sample_mem (
  input  logic                             clk,
  input  msm_pkg::sample_wr_t              wr,
  input  logic [msm_pkg::MEM_ADDR_BITS-1:0] rd_addr,
  output logic [15:0]                      rd_data
);
  import msm_pkg::*;

  logic [15:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/msm_chan_mem.sv =====
// Channel table of the mixer: base, length and position of each voice.
// One write port, one read port with registered data. Depends on msm_pkg.
module msm_chan_mem (
  input  logic                       clk,
  input  msm_pkg::chan_wr_t          wr,
  input  logic [msm_pkg::CH_BITS-1:0] rd_addr,
  output msm_pkg::chan_entry_t       rd_data
);
  import msm_pkg::*;

  chan_entry_t mem [MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/multichannel_sample_mixer_core.sv =====
// Top level of the multichannel sample mixer: request sequencer, active
// flags, mix accumulators and output register. Depends on msm_pkg,
// msm_sample_mem and msm_chan_mem.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    req_type, addresses, bytes, length
//   out_     output     out_valid/out_ready  left_out, right_out (tick only)
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A memory write or a channel start is done in the cycle it is accepted.
// A tick walks the n channels in use through the channel table and then the
// sample memory, one channel per cycle. The next request is accepted once
// the walk has drained and the sums have been loaded into the output
// register. Reset leaves every channel inactive, num_channels 8. A finished
// tick waits for the output register to free up before the next request is
// accepted; cfg_ready is always high.
module multichannel_sample_mixer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [15:0]        in_mem_addr,
  input  logic signed [7:0]  in_left_in,
  input  logic signed [7:0]  in_right_in,
  input  logic [15:0]        in_sample_base,
  input  logic [16:0]        in_sample_len,
  input  logic [2:0]         in_channel_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [7:0]  out_left_out,
  output logic signed [7:0]  out_right_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [3:0]         cfg_data
);
  import msm_pkg::*;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         rd_cnt_r;
  logic                     s1_v_r;
  logic [CH_BITS-1:0]       s1_idx_r;
  logic                     s2_v_r;
  logic [7:0]               acc_l_r, acc_r_r;
  logic                     out_valid_r;
  logic [7:0]               out_l_r, out_r_r;
  logic [3:0]               num_ch_r, num_prot_r;
  logic [MAX_CHANNELS-1:0]  active_r;

  logic [CNT_W-1:0]         used_n;
  logic                     in_fire;
  req_t                     req;
  logic                     free_found;
  logic [CH_BITS-1:0]       free_idx;
  logic [CH_BITS-1:0]       ch_idx;
  logic                     ch_ok;
  logic                     rd_issue;
  logic                     s1_live;
  logic                     out_load;

  chan_wr_t                 chan_wr;
  chan_entry_t              chan_rdata;
  logic [CH_BITS-1:0]       chan_rd_addr;
  sample_wr_t               sample_wr;
  logic [MEM_ADDR_BITS-1:0] sample_rd_addr;
  logic [15:0]              sample_rdata;

  logic                     set_en, clr_en;
  logic [CH_BITS-1:0]       set_idx;
  logic [LEN_W-1:0]         new_pos;
  logic [LEN_W:0]           addr_sum;
  logic                     chan_done;

  msm_sample_mem u_sample_mem (
    .clk     (clk),
    .wr      (sample_wr),
    .rd_addr (sample_rd_addr),
    .rd_data (sample_rdata)
  );

  msm_chan_mem u_chan_mem (
    .clk     (clk),
    .wr      (chan_wr),
    .rd_addr (chan_rd_addr),
    .rd_data (chan_rdata)
  );

  assign req     = req_t'(in_req_type);
  assign in_fire = in_valid && in_ready;
  assign used_n  = (CNT_W'(num_ch_r) > CNT_W'(MAX_CHANNELS)) ?
                   CNT_W'(MAX_CHANNELS) : CNT_W'(num_ch_r);
  assign ch_idx  = CH_BITS'(in_channel_index);
  assign ch_ok   = (CNT_W'(in_channel_index) < CNT_W'(MAX_CHANNELS));

  // First inactive channel in [num_protected, used_n).
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (!free_found && (CNT_W'(i) >= CNT_W'(num_prot_r)) && (CNT_W'(i) < used_n)
          && !active_r[i]) begin
        free_found = 1'b1;
        free_idx   = CH_BITS'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && req == REQ_TICK) begin
          state_nxt = ST_TICK;
        end
      end
      ST_TICK: begin
        if (rd_cnt_r == used_n && !s1_v_r && !s2_v_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    rd_issue       = (state_r == ST_TICK) && (rd_cnt_r < used_n);
    out_load       = (state_r == ST_FIN) && (!out_valid_r || out_ready);
    chan_rd_addr   = rd_cnt_r[CH_BITS-1:0];
    s1_live        = s1_v_r && active_r[s1_idx_r];
    new_pos        = LEN_W'({1'b0, chan_rdata.pos} + 18'd1);
    chan_done      = ({1'b0, new_pos} + 18'd1) >= {1'b0, chan_rdata.len};
    addr_sum       = {2'b00, chan_rdata.base} + {1'b0, chan_rdata.pos};
    sample_rd_addr = MEM_ADDR_BITS'(addr_sum);

    sample_wr      = '0;
    chan_wr        = '0;
    set_en         = 1'b0;
    set_idx        = '0;
    clr_en         = 1'b0;

    if (in_fire) begin
      case (req)
        REQ_WRITE: begin
          sample_wr.we   = 1'b1;
          sample_wr.addr = MEM_ADDR_BITS'(in_mem_addr);
          sample_wr.data = {in_right_in, in_left_in};
        end
        REQ_PLAY_FREE: begin
          set_en  = free_found;
          set_idx = free_idx;
        end
        REQ_PLAY_CH: begin
          set_en  = ch_ok;
          set_idx = ch_idx;
        end
        default: ;
      endcase
      chan_wr.we        = set_en;
      chan_wr.addr      = set_idx;
      chan_wr.data.base = in_sample_base;
      chan_wr.data.len  = in_sample_len;
      chan_wr.data.pos  = '0;
    end else if (s1_live) begin
      // Write back the advanced position of the channel just read.
      chan_wr.we        = 1'b1;
      chan_wr.addr      = s1_idx_r;
      chan_wr.data.base = chan_rdata.base;
      chan_wr.data.len  = chan_rdata.len;
      chan_wr.data.pos  = new_pos;
      clr_en            = chan_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      s1_v_r      <= 1'b0;
      s1_idx_r    <= '0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      num_ch_r    <= 4'd8;
      num_prot_r  <= 4'd0;
      active_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && req == REQ_TICK) begin
        rd_cnt_r <= '0;
      end else if (rd_issue) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
      s1_v_r   <= rd_issue;
      s1_idx_r <= rd_cnt_r[CH_BITS-1:0];
      s2_v_r   <= s1_live;
      if (set_en) begin
        active_r[set_idx] <= 1'b1;
      end else if (clr_en) begin
        active_r[s1_idx_r] <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NUM_CHANNELS:  num_ch_r   <= cfg_data;
          CFG_NUM_PROTECTED: num_prot_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && req == REQ_TICK) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (s2_v_r) begin
      acc_l_r <= acc_l_r + sample_rdata[7:0];
      acc_r_r <= acc_r_r + sample_rdata[15:8];
    end
    if (out_load) begin
      out_l_r <= acc_l_r;
      out_r_r <= acc_r_r;
    end
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_left_out  = $signed(out_l_r);
  assign out_right_out = $signed(out_r_r);

`ifndef SYNTHESIS
  a_s2_follows_live: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> $past(s1_v_r && active_r[s1_idx_r]))
    else $error("sample read pending without a live channel read");

  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (!s1_v_r && !s2_v_r))
    else $error("tick finished with reads still in flight");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK) |-> (rd_cnt_r <= used_n))
    else $error("channel read counter ran past channels in use");

  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req == REQ_TICK) |=> (state_r == ST_TICK && rd_cnt_r == '0))
    else $error("accepted tick did not start the channel walk");
`endif

endmodule
